// ----- hdl/tmc_pkg.sv -----
// Shared constants for the triangle measure and classify block.
package tmc_pkg;

  // Fixed result field widths
  localparam int unsigned PERIM_W = 35;
  localparam int unsigned AREA_W  = 33;

endpackage

// ----- hdl/tmc_side_lane.sv -----
// One side lane: squared side length and a bit-per-stage pipelined fixed-point square root.
module tmc_side_lane #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned DIFF = COORD_BITS + 1,
  localparam int unsigned SQ   = 2 * COORD_BITS + 2,
  localparam int unsigned ROOT = COORD_BITS + 1 + FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic [ROOT:0]                en_i,
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  output logic [ROOT-1:0]              root_o,
  output logic [SQ-1:0]                sq_o
);

  localparam int unsigned W2  = 2 * ROOT;
  localparam int unsigned REM = ROOT + 2;

  logic signed [DIFF-1:0] dx, dy;
  logic signed [SQ-1:0]   dxx, dyy;
  logic [SQ-1:0]          sq_d;

  logic [SQ-1:0]   sq_q   [0:ROOT];
  logic [REM-1:0]  rem_q  [1:ROOT-1];
  logic [ROOT-1:0] root_q [1:ROOT];
  logic [W2-1:0]   rad_q  [1:ROOT-1];

  assign dx   = DIFF'(x1_i) - DIFF'(x0_i);
  assign dy   = DIFF'(y1_i) - DIFF'(y0_i);
  assign dxx  = dx * dx;
  assign dyy  = dy * dy;
  assign sq_d = $unsigned(dxx) + $unsigned(dyy);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_q[0] <= sq_d;
    end
  end

  // One root bit per stage: bring down two radicand bits, try root*4+1
  for (genvar j = 1; j <= ROOT; j++) begin : g_stage
    logic [REM-1:0]  rem_in, t, trial, rem_d;
    logic [ROOT-1:0] root_in, root_d;
    logic [W2-1:0]   rad_in;
    logic            ge;

    if (j == 1) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = W2'(sq_q[0]) << (2 * FRAC_BITS);
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    assign t      = {rem_in[ROOT-1:0], rad_in[W2-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (t >= trial);
    assign rem_d  = ge ? (t - trial) : t;
    assign root_d = {root_in[ROOT-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        sq_q[j]   <= sq_q[j-1];
        root_q[j] <= root_d;
      end
    end

    if (j < ROOT) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          rem_q[j] <= rem_d;
          rad_q[j] <= rad_in << 2;
        end
      end
    end
  end

  assign root_o = root_q[ROOT];
  assign sq_o   = sq_q[ROOT];

endmodule

// ----- hdl/tmc_area.sv -----
// Doubled area: cross product magnitude, delayed to line up with the side lanes.
module tmc_area #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned DIFF = COORD_BITS + 1,
  localparam int unsigned ROOT = COORD_BITS + 1 + FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic [ROOT:0]                en_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  output logic [2*DIFF-1:0]            area_o
);

  localparam int unsigned PW = 2 * DIFF;

  logic signed [DIFF-1:0] d1x, d1y, d2x, d2y;
  logic signed [PW-1:0]   p1_d, p2_d, p1_q, p2_q;
  logic signed [PW:0]     cprod;
  logic [PW:0]            mag;
  logic [PW-1:0]          area_q [1:ROOT];

  assign d1x  = DIFF'(bx_i) - DIFF'(ax_i);
  assign d1y  = DIFF'(by_i) - DIFF'(ay_i);
  assign d2x  = DIFF'(cx_i) - DIFF'(ax_i);
  assign d2y  = DIFF'(cy_i) - DIFF'(ay_i);
  assign p1_d = d1x * d2y;
  assign p2_d = d1y * d2x;

  assign cprod = (PW + 1)'(p1_q) - (PW + 1)'(p2_q);
  assign mag   = cprod[PW] ? $unsigned(-cprod) : $unsigned(cprod);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (en_i[1]) begin
      area_q[1] <= mag[PW-1:0];
    end
  end

  // Hold the magnitude alongside the root stages
  for (genvar j = 2; j <= ROOT; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        area_q[j] <= area_q[j-1];
      end
    end
  end

  assign area_o = area_q[ROOT];

endmodule

// ----- hdl/tmc_merge.sv -----
// Merge stage: sums the three roots, compares squared sides, registers the result word.
module tmc_merge #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned DIFF = COORD_BITS + 1,
  localparam int unsigned SQ   = 2 * COORD_BITS + 2,
  localparam int unsigned ROOT = COORD_BITS + 1 + FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ROOT-1:0]              root_a_i,
  input  logic [ROOT-1:0]              root_b_i,
  input  logic [ROOT-1:0]              root_c_i,
  input  logic [SQ-1:0]                sq_a_i,
  input  logic [SQ-1:0]                sq_b_i,
  input  logic [SQ-1:0]                sq_c_i,
  input  logic [2*DIFF-1:0]            area_i,
  output logic [tmc_pkg::PERIM_W-1:0]  perimeter_o,
  output logic [tmc_pkg::AREA_W-1:0]   area_doubled_o,
  output logic                         is_right_o,
  output logic                         is_isosceles_o
);

  localparam int unsigned PS = ROOT + 2;
  localparam int unsigned SW = SQ + 1;

  logic [PS-1:0] psum;
  logic [SW-1:0] ea, eb, ec;
  logic          right_d, isos_d;

  assign psum = PS'(root_a_i) + PS'(root_b_i) + PS'(root_c_i);
  assign ea   = SW'(sq_a_i);
  assign eb   = SW'(sq_b_i);
  assign ec   = SW'(sq_c_i);

  assign right_d = (ea == eb + ec) || (eb == ea + ec) || (ec == ea + eb);
  assign isos_d  = (sq_a_i == sq_b_i) || (sq_b_i == sq_c_i) || (sq_c_i == sq_a_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      perimeter_o    <= tmc_pkg::PERIM_W'(psum);
      area_doubled_o <= tmc_pkg::AREA_W'(area_i);
      is_right_o     <= right_d;
      is_isosceles_o <= isos_d;
    end
  end

endmodule

// ----- hdl/triangle_measure_classify.sv -----
// Top level of the triangle measure and classify block.
//
// Usage: present one triangle (three vertices, signed coordinates) as an
// input word with in_valid_i; it is taken on a rising edge where in_stall_o
// is low. Each word yields one result word on the output channel: the
// perimeter (sum of three square roots, FRAC_BITS fraction bits), twice the
// area, and right-angle and isosceles flags, taken where out_stall_i is low.
//
// Three side lanes run side by side, each forming one squared side and its
// root with one root bit resolved per pipeline stage; a cross-product path
// runs beside them, and a merge stage sums the roots and compares sides.
// Depth: COORD_BITS + FRAC_BITS + 3 register stages, most of which are
// the per-bit root stages.
// Throughput: one word per cycle with no stall.
// Stall: a held output freezes only the stages that are full behind it;
// empty stages still fill, so in_stall_o rises once the pipe is packed.
// Reset: clears all stage valid bits; no result is pending afterward.
module triangle_measure_classify #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tmc_pkg::PERIM_W-1:0]  perimeter_o,
  output logic [tmc_pkg::AREA_W-1:0]   area_doubled_o,
  output logic                         is_right_o,
  output logic                         is_isosceles_o
);

  localparam int unsigned DIFF  = COORD_BITS + 1;
  localparam int unsigned SQ    = 2 * COORD_BITS + 2;
  localparam int unsigned ROOT  = COORD_BITS + 1 + FRAC_BITS;
  localparam int unsigned DEPTH = ROOT + 2;

  logic [DEPTH-1:0] valid_q, valid_d, ready;
  logic [ROOT-1:0]  root_a, root_b, root_c;
  logic [SQ-1:0]    sq_a, sq_b, sq_c;
  logic [2*DIFF-1:0] area;

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    ready[DEPTH-1] = !valid_q[DEPTH-1] || !out_stall_i;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < DEPTH; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[DEPTH-1];

  // Side a = BC, b = CA, c = AB
  tmc_side_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_a (
    .clk_i (clk_i), .en_i (ready[ROOT:0]),
    .x0_i (bx_i), .y0_i (by_i), .x1_i (cx_i), .y1_i (cy_i),
    .root_o (root_a), .sq_o (sq_a)
  );

  tmc_side_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk_i (clk_i), .en_i (ready[ROOT:0]),
    .x0_i (cx_i), .y0_i (cy_i), .x1_i (ax_i), .y1_i (ay_i),
    .root_o (root_b), .sq_o (sq_b)
  );

  tmc_side_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_c (
    .clk_i (clk_i), .en_i (ready[ROOT:0]),
    .x0_i (ax_i), .y0_i (ay_i), .x1_i (bx_i), .y1_i (by_i),
    .root_o (root_c), .sq_o (sq_c)
  );

  tmc_area #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_area (
    .clk_i (clk_i), .en_i (ready[ROOT:0]),
    .ax_i (ax_i), .ay_i (ay_i), .bx_i (bx_i), .by_i (by_i),
    .cx_i (cx_i), .cy_i (cy_i),
    .area_o (area)
  );

  tmc_merge #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_merge (
    .clk_i          (clk_i),
    .en_i           (ready[DEPTH-1]),
    .root_a_i       (root_a),
    .root_b_i       (root_b),
    .root_c_i       (root_c),
    .sq_a_i         (sq_a),
    .sq_b_i         (sq_b),
    .sq_c_i         (sq_c),
    .area_i         (area),
    .perimeter_o    (perimeter_o),
    .area_doubled_o (area_doubled_o),
    .is_right_o     (is_right_o),
    .is_isosceles_o (is_isosceles_o)
  );

endmodule

// ----- tb/sv/triangle_measure_classify_tb.sv -----
// Self-checking testbench for the triangle measure and classify block.
`timescale 1ns / 100ps

module triangle_measure_classify_tb;

  localparam int unsigned CW = 16;
  localparam int unsigned FB = 16;
  localparam int unsigned LATENCY = CW + FB + 3;
  localparam longint unsigned CYCLE_LIMIT = 400_000;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  } tri_word_t;

  typedef struct packed {
    logic [tmc_pkg::PERIM_W-1:0] perimeter;
    logic [tmc_pkg::AREA_W-1:0]  area_doubled;
    logic                        is_right;
    logic                        is_isosceles;
  } measure_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] ax_i = '0, ay_i = '0, bx_i = '0, by_i = '0, cx_i = '0, cy_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [tmc_pkg::PERIM_W-1:0] perimeter_o;
  logic [tmc_pkg::AREA_W-1:0] area_doubled_o;
  logic is_right_o, is_isosceles_o;

  tri_word_t pending_words[$];
  measure_t  expected_measures[$];
  int unsigned fail_count = 0;
  longint unsigned cycle_count = 0;
  bit stim_done = 1'b0;
  // Long receiver hold-off requested by the stimulus process.
  int unsigned hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  triangle_measure_classify #(.COORD_BITS(CW), .FRAC_BITS(FB)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .ax_i, .ay_i, .bx_i, .by_i, .cx_i, .cy_i,
    .out_valid_o, .out_stall_i,
    .perimeter_o, .area_doubled_o, .is_right_o, .is_isosceles_o
  );

  // floor(sqrt(s2) * 2^FB), bit by bit on a 128-bit radicand
  function automatic logic [63:0] fixed_sqrt(logic [63:0] s2);
    logic [127:0] radicand;
    logic [63:0] root;
    logic [63:0] trial;
    radicand = {64'd0, s2} << (2 * FB);
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if ({64'd0, trial} * {64'd0, trial} <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic measure_t measure_triangle(tri_word_t w);
    measure_t m;
    longint sa, sb, sc, cp, dx, dy;
    longint unsigned perim;
    dx = longint'(w.cx) - w.bx; dy = longint'(w.cy) - w.by; sa = dx * dx + dy * dy;
    dx = longint'(w.ax) - w.cx; dy = longint'(w.ay) - w.cy; sb = dx * dx + dy * dy;
    dx = longint'(w.bx) - w.ax; dy = longint'(w.by) - w.ay; sc = dx * dx + dy * dy;
    perim = fixed_sqrt(sa) + fixed_sqrt(sb) + fixed_sqrt(sc);
    cp = (longint'(w.bx) - w.ax) * (longint'(w.cy) - w.ay)
       - (longint'(w.by) - w.ay) * (longint'(w.cx) - w.ax);
    if (cp < 0) cp = -cp;
    m.perimeter = perim[tmc_pkg::PERIM_W-1:0];
    m.area_doubled = cp[tmc_pkg::AREA_W-1:0];
    m.is_right = (sa == sb + sc) || (sb == sa + sc) || (sc == sa + sb);
    m.is_isosceles = (sa == sb) || (sb == sc) || (sc == sa);
    return m;
  endfunction

  function automatic int unsigned gap_len();
    // mostly short, occasionally long
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    unique case ($urandom_range(5))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1, 2: return CW'($signed($urandom_range(20)) - 10);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic tri_word_t make_tri(int ax, int ay, int bx, int by, int cx, int cy);
    tri_word_t w;
    w.ax = CW'(ax); w.ay = CW'(ay); w.bx = CW'(bx);
    w.by = CW'(by); w.cx = CW'(cx); w.cy = CW'(cy);
    return w;
  endfunction

  // Driver: advance to the next word on accept, insert random gaps.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_measures.push_back(measure_triangle({ax_i, ay_i, bx_i, by_i, cx_i, cy_i}));
        void'(pending_words.pop_front());
        send_gap = gap_len();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap == 0 && pending_words.size() > 0) begin
          in_valid_i <= 1'b1;
          {ax_i, ay_i, bx_i, by_i, cx_i, cy_i} <= pending_words[0];
        end else begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Monitor: check each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin
    measure_t exp_m;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_measures.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          exp_m = expected_measures.pop_front();
          if (perimeter_o !== exp_m.perimeter) begin
            $error("perimeter: expected %0d, got %0d", exp_m.perimeter, perimeter_o);
            fail_count++;
          end
          if (area_doubled_o !== exp_m.area_doubled) begin
            $error("area_doubled: expected %0d, got %0d", exp_m.area_doubled, area_doubled_o);
            fail_count++;
          end
          if (is_right_o !== exp_m.is_right) begin
            $error("is_right: expected %0d, got %0d", exp_m.is_right, is_right_o);
            fail_count++;
          end
          if (is_isosceles_o !== exp_m.is_isosceles) begin
            $error("is_isosceles: expected %0d, got %0d", exp_m.is_isosceles, is_isosceles_o);
            fail_count++;
          end
        end
      end
      // Stall: long hold-off when requested, else random stalls at a low or high rate.
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else if (stim_done || cycle_count < 2000 || $urandom_range(3) != 0) begin
        out_stall_i <= ($urandom_range(7) == 0) && !stim_done;
      end else begin
        out_stall_i <= ($urandom_range(1) == 0);
      end
    end
  end

  // Watchdog on a plain cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, degenerate cases, right and isosceles shapes.
    pending_words.push_back(make_tri(0, 0, 0, 0, 0, 0));
    pending_words.push_back(make_tri(1, 1, 2, 2, 3, 3));
    pending_words.push_back(make_tri(5, 5, 5, 5, 9, 2));
    pending_words.push_back(make_tri(0, 0, 3, 0, 0, 4));
    pending_words.push_back(make_tri(0, 0, 4, 0, 2, 7));
    pending_words.push_back(make_tri(0, 0, 1, 0, 0, 1));
    pending_words.push_back(make_tri(0, 0, 2, 0, 1, 5));
    pending_words.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
    pending_words.push_back(make_tri(-32768, -32768, 32767, 32767, -32768, 32767));
    pending_words.push_back(make_tri(32767, 32767, -32768, -32768, 32767, -32768));
    pending_words.push_back(make_tri(-32768, 32767, 32767, -32768, 0, 0));
    pending_words.push_back(make_tri(-1, -1, -1, -1, -1, -1));
    pending_words.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767));
    pending_words.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_words.push_back(make_tri(0, 0, 2, 0, 1, 1));
    pending_words.push_back(make_tri(-3, -4, 0, 0, 3, 4));
    pending_words.push_back(make_tri(100, -7, -5, 200, 31, 31));

    // Random: let the first part drain through short gaps before pressure.
    repeat (150) pending_words.push_back(make_tri(rand_coord(), rand_coord(), rand_coord(),
                                                  rand_coord(), rand_coord(), rand_coord()));
    while (pending_words.size() > 60) @(posedge clk_i);
    // Hold the output long enough for the pipe to pack and stall its input.
    hold_cycles = 20 * LATENCY;
    repeat (250) pending_words.push_back(make_tri(rand_coord(), rand_coord(), rand_coord(),
                                                  rand_coord(), rand_coord(), rand_coord()));

    while (pending_words.size() > 0 || in_valid_i) @(posedge clk_i);
    stim_done = 1'b1;
    while (expected_measures.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
